// ----- rtl/tcs_pkg.sv -----
// tcs_pkg: shared types and codes of the timed command slot scheduler
// no dependencies; imported by every module of the block
package tcs_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FrameLen = 4;

  localparam logic [CfgIdxW-1:0] REG_START = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END   = 2'd1;

  localparam logic [1:0] OP_SCHED = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_NOW   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  cmd_byte;
    logic [31:0] due_time;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
  } out_item_t;

  // what one cell reports while it holds the scan token
  typedef struct packed {
    logic       fire;
    logic       take;
    logic [7:0] cmd;
  } cell_stat_t;

  // scan side to frame emitter
  typedef struct packed {
    logic       load;
    logic [7:0] cmd;
    logic       finish;
  } emit_ctl_t;

  // frame emitter back to scan side
  typedef struct packed {
    logic idle;
    logic hold;
    logic can_load;
  } emit_stat_t;

endpackage

// ----- rtl/tcs_cell.sv -----
// tcs_cell: one slot of the scheduler chain, holds due time, command and scan token
// depends on tcs_pkg
module tcs_cell
  import tcs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_i,
  input  logic                 adv_i,
  input  logic [1:0]           op_i,
  input  logic [7:0]           cmd_i,
  input  logic [TIME_BITS-1:0] due_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 placed_i,
  output logic                 tok_o,
  output cell_stat_t           stat_o
);

  logic                 tok_q, tok_d;
  logic [TIME_BITS-1:0] due_q, due_d;
  logic [7:0]           cmd_q, cmd_d;
  logic                 free;

  assign free = (due_q == '0);

  assign stat_o.fire = tok_q && (op_i == OP_TICK) && !free && (due_q < now_i);
  assign stat_o.take = tok_q && (op_i == OP_SCHED) && free && !placed_i;
  assign stat_o.cmd  = cmd_q;

  assign tok_o = tok_q && adv_i;

  always_comb begin
    tok_d = tok_i || (tok_q && !adv_i);
    due_d = due_q;
    cmd_d = cmd_q;
    if (stat_o.take && adv_i) begin
      due_d = due_i;
      cmd_d = cmd_i;
    end else if (stat_o.fire && adv_i) begin
      due_d = '0;
      cmd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      due_q <= '0;
      cmd_q <= '0;
    end else begin
      tok_q <= tok_d;
      due_q <= due_d;
      cmd_q <= cmd_d;
    end
  end

endmodule

// ----- rtl/tcs_emitter.sv -----
// tcs_emitter: byte-serial frame sender with a held end byte for the last-flag decision
// depends on tcs_pkg
module tcs_emitter
  import tcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  emit_ctl_t  ctl_i,
  input  logic [7:0] start_byte_i,
  input  logic [7:0] end_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  output emit_stat_t stat_o
);

  localparam logic [2:0] E_IDLE     = 3'd0;
  localparam logic [2:0] E_PREV_END = 3'd1;
  localparam logic [2:0] E_START    = 3'd2;
  localparam logic [2:0] E_LEN      = 3'd3;
  localparam logic [2:0] E_CMD      = 3'd4;
  localparam logic [2:0] E_HOLD     = 3'd5;
  localparam logic [2:0] E_FINAL    = 3'd6;

  logic [2:0] state_q, state_d;
  logic [7:0] cmd_q, cmd_d;
  logic       out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  assign stat_o.idle     = (state_q == E_IDLE);
  assign stat_o.hold     = (state_q == E_HOLD);
  assign stat_o.can_load = stat_o.idle || stat_o.hold;

  always_comb begin
    out_valid_o         = 1'b0;
    out_data_o.tx_byte  = end_byte_i;
    out_data_o.run_last = 1'b0;
    case (state_q)
      E_PREV_END: begin
        out_valid_o = 1'b1;
      end
      E_START: begin
        out_valid_o        = 1'b1;
        out_data_o.tx_byte = start_byte_i;
      end
      E_LEN: begin
        out_valid_o        = 1'b1;
        out_data_o.tx_byte = 8'(FrameLen);
      end
      E_CMD: begin
        out_valid_o        = 1'b1;
        out_data_o.tx_byte = cmd_q;
      end
      E_FINAL: begin
        out_valid_o         = 1'b1;
        out_data_o.run_last = 1'b1;
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    if (ctl_i.load && stat_o.can_load) begin
      cmd_d = ctl_i.cmd;
    end
    case (state_q)
      E_IDLE: begin
        if (ctl_i.load) state_d = E_START;
      end
      E_HOLD: begin
        // another frame follows, so the held end byte is not the last one
        if (ctl_i.load) state_d = E_PREV_END;
        else if (ctl_i.finish) state_d = E_FINAL;
      end
      E_PREV_END: begin
        if (out_fire) state_d = E_START;
      end
      E_START: begin
        if (out_fire) state_d = E_LEN;
      end
      E_LEN: begin
        if (out_fire) state_d = E_CMD;
      end
      E_CMD: begin
        if (out_fire) state_d = E_HOLD;
      end
      E_FINAL: begin
        if (out_fire) state_d = E_IDLE;
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ----- rtl/timed_command_slot_scheduler.sv -----
// timed_command_slot_scheduler: top level, slot chain, scan control and frame emitter
// depends on tcs_pkg, tcs_cell, tcs_emitter
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o     | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i   | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i, no wait           | cfg_idx_i, cfg_wdata_i
//
// one transaction is worked on at a time: a scan token walks the slot chain one cell per
// cycle while no due slot waits for the emitter; a send-now sends one frame of start byte,
// length, command and end byte, the end byte flagged last
// the byte-serial emitter sets the frame cost; a due slot that meets a busy emitter freezes the token in place
// reset clears every slot to free and loads start byte 2 and end byte 3
// the end byte of each frame is held until the scan knows whether another frame follows
module timed_command_slot_scheduler
  import tcs_pkg::*;
#(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  // configuration registers
  logic [7:0] start_byte_q, end_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'd2;
      end_byte_q   <= 8'd3;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_START) start_byte_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_END)   end_byte_q   <= cfg_wdata_i;
    end
  end

  // time fields cut or widened to the slot time width
  logic [TIME_BITS-1:0] due_w, now_w;

  if (TIME_BITS <= 32) begin : g_time_cut
    assign due_w = in_data_i.due_time[TIME_BITS-1:0];
    assign now_w = in_data_i.now_time[TIME_BITS-1:0];
  end else begin : g_time_wide
    assign due_w = {{(TIME_BITS-32){1'b0}}, in_data_i.due_time};
    assign now_w = {{(TIME_BITS-32){1'b0}}, in_data_i.now_time};
  end

  // request held for the whole scan
  logic [1:0]           op_q;
  logic [7:0]           cmd_q;
  logic [TIME_BITS-1:0] due_q, now_q;
  logic                 placed_q, fin_q;

  logic        in_fire, busy, adv, scan_go, now_go, fin_clr;
  logic        fire_any, take_any;
  logic [7:0]  fire_cmd;
  emit_ctl_t   emit_ctl;
  emit_stat_t  emit_stat;

  logic       [SLOTS:0]   tok;
  cell_stat_t [SLOTS-1:0] cstat;

  // a token moving on shows at a cell output; a frozen token keeps the emitter busy
  assign busy       = (|tok[SLOTS:1]) || fin_q || !emit_stat.idle;
  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_go    = in_fire && ((in_data_i.op == OP_SCHED) || (in_data_i.op == OP_TICK));
  assign now_go     = in_fire && (in_data_i.op == OP_NOW);

  // token enters the first cell as the transaction is taken
  assign tok[0] = scan_go;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tcs_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[i]),
      .adv_i   (adv),
      .op_i    (op_q),
      .cmd_i   (cmd_q),
      .due_i   (due_q),
      .now_i   (now_q),
      .placed_i(placed_q),
      .tok_o   (tok[i+1]),
      .stat_o  (cstat[i])
    );
  end

  // at most one cell holds the token, so the or-reduction picks that cell
  always_comb begin
    fire_any = 1'b0;
    take_any = 1'b0;
    fire_cmd = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fire_any = fire_any | cstat[i].fire;
      take_any = take_any | cstat[i].take;
      fire_cmd = fire_cmd | (cstat[i].cmd & {8{cstat[i].fire}});
    end
  end

  // a due slot waits in place until the emitter can take its frame
  assign adv = !fire_any || emit_stat.can_load;

  assign emit_ctl.load   = (fire_any && emit_stat.can_load) || now_go;
  assign emit_ctl.cmd    = now_go ? in_data_i.cmd_byte : fire_cmd;
  assign emit_ctl.finish = fin_q;

  // scan finished: last frame may now close with the last flag
  assign fin_clr = fin_q && (emit_stat.idle || emit_stat.hold) && !emit_ctl.load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      if (in_fire) placed_q <= 1'b0;
      else if (take_any && adv) placed_q <= 1'b1;
      if (tok[SLOTS] || now_go) fin_q <= 1'b1;
      else if (fin_clr) fin_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_data_i.op;
      cmd_q <= in_data_i.cmd_byte;
      due_q <= due_w;
      now_q <= now_w;
    end
  end

  tcs_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (emit_ctl),
    .start_byte_i(start_byte_q),
    .end_byte_i  (end_byte_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (emit_stat)
  );

endmodule

// ----- rtl/tcs_checker.sv -----
// tcs_checker: port-level assertions for the timed command slot scheduler
// depends on tcs_pkg; bound to timed_command_slot_scheduler
module tcs_checker
  import tcs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input in_item_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_item_t          out_data_o
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // no new transaction while bytes are still owed
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while output busy");

  // a send-now starts its frame in the next cycle
  a_now_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_NOW) |=> out_valid_o)
    else $error("send-now frame did not start");

  // nothing follows the byte flagged last
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.run_last |=> !out_valid_o)
    else $error("output continued after last byte");

endmodule

bind timed_command_slot_scheduler tcs_checker u_tcs_checker (.*);
